FILE: rtl/core/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
package mtep_pkg;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_MLEN   = 3'd5,
    PH_MBODY  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_CHANNEL = 3'd0,
    EV_TEMPO   = 3'd1,
    EV_EOT     = 3'd2,
    EV_META    = 3'd3,
    EV_ERROR   = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_MUL  = 2'd2,
    ST_OUT  = 2'd3
  } ctrl_e;

  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [7:0] MetaEot   = 8'h2F;
  localparam logic [7:0] StatMeta  = 8'hFF;

  // One track's parse context.
  typedef struct packed {
    phase_e      phase;
    logic [27:0] delta;
    logic [1:0]  dcount;
    logic [7:0]  rstat;
    logic [7:0]  cstat;
    logic [6:0]  held;
    logic [6:0]  mkind;
    logic [7:0]  left;
    logic [23:0] tempo;
    logic        done;
  } track_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  track;
    event_e      kind;
    logic [27:0] delta;
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic        single;
    logic [6:0]  mtype;
    logic [23:0] tempo;
    logic [27:0] period;
  } result_t;

endpackage

FILE: rtl/core/mtep_divider.sv
// Restoring divider for tempo over ticks per beat, one quotient bit per cycle.
module mtep_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [23:0] quot_o
);
  logic [23:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;
  logic [16:0] shifted;

  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_o  = 1'b0;
    shifted = {rem_q[15:0], quot_q[23]};
    trial   = shifted - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = (divisor_i == 16'd0) ? 16'd1 : divisor_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_d  = trial;
        quot_d = {quot_q[22:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_d;
endmodule

FILE: rtl/core/mtep_step.sv
// Per-byte parse step: next track context and the result it causes.
module mtep_step (
  input  mtep_pkg::track_t  cur_i,
  input  logic [7:0]        byte_i,
  input  logic [3:0]        track_i,
  output mtep_pkg::track_t  nxt_o,
  output logic              fire_o,
  output mtep_pkg::result_t res_o
);
  import mtep_pkg::*;

  logic [7:0] b;
  logic       data_b;
  logic [7:0] s;
  logic [6:0] d2;
  logic       one;
  logic [7:0] left_m1;

  assign b = byte_i;
  assign data_b = ~b[7];
  assign left_m1 = cur_i.left - 8'd1;

  always_comb begin
    nxt_o  = cur_i;
    fire_o = 1'b0;
    res_o  = '0;
    res_o.track = track_i;
    res_o.delta = cur_i.delta;
    s  = cur_i.cstat;
    d2 = b[6:0];
    one = 1'b0;
    case (cur_i.phase)
      PH_DELTA: begin
        nxt_o.delta = {cur_i.delta[20:0], b[6:0]};
        if (b[7] && cur_i.dcount != 2'd3) nxt_o.dcount = cur_i.dcount + 2'd1;
        else nxt_o.phase = PH_STATUS;
      end
      PH_STATUS: begin
        if (data_b) begin
          if (cur_i.rstat inside {[8'h80:8'hEF]}) begin
            nxt_o.cstat = cur_i.rstat;
            if (cur_i.rstat inside {[8'hC0:8'hDF]}) begin
              fire_o = 1'b1;
              s = cur_i.rstat;
              one = 1'b1;
              res_o.d1 = b[6:0];
            end else begin
              nxt_o.held  = b[6:0];
              nxt_o.phase = PH_DATA2;
            end
          end else begin
            fire_o = 1'b1;
            res_o.kind = EV_ERROR;
            res_o.status = b;
          end
        end else if (b == StatMeta) begin
          nxt_o.phase = PH_MTYPE;
        end else if (b <= 8'hEF) begin
          nxt_o.rstat = b;
          nxt_o.cstat = b;
          nxt_o.phase = PH_DATA1;
        end else begin
          fire_o = 1'b1;
          res_o.kind = EV_ERROR;
          res_o.status = b;
        end
      end
      PH_DATA1: begin
        if (!data_b) begin
          fire_o = 1'b1;
          res_o.kind = EV_ERROR;
          res_o.status = b;
        end else if (cur_i.cstat inside {[8'hC0:8'hDF]}) begin
          fire_o = 1'b1;
          one = 1'b1;
          res_o.d1 = b[6:0];
        end else begin
          nxt_o.held  = b[6:0];
          nxt_o.phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        fire_o = 1'b1;
        if (!data_b) begin
          res_o.kind = EV_ERROR;
          res_o.status = b;
        end else begin
          res_o.d1 = cur_i.held;
          if (s[7:4] == 4'h9 && d2 == 7'd0) begin
            s  = s & 8'h8F;
            d2 = 7'h7F;
          end
          res_o.d2 = d2;
        end
      end
      PH_MTYPE: begin
        if (!data_b) begin
          fire_o = 1'b1;
          res_o.kind = EV_ERROR;
          res_o.status = b;
        end else begin
          nxt_o.mkind = b[6:0];
          nxt_o.phase = PH_MLEN;
        end
      end
      PH_MLEN: begin
        nxt_o.left  = b;
        nxt_o.tempo = '0;
        if (b == 8'd0) fire_o = 1'b1;
        else nxt_o.phase = PH_MBODY;
      end
      PH_MBODY: begin
        if ({1'b0, cur_i.mkind} == MetaTempo) nxt_o.tempo = {cur_i.tempo[15:0], b};
        nxt_o.left = left_m1;
        if (left_m1 == 8'd0) fire_o = 1'b1;
      end
      default: nxt_o.phase = PH_DELTA;
    endcase
    // channel result fields
    if (fire_o && res_o.kind == EV_CHANNEL &&
        (cur_i.phase == PH_STATUS || cur_i.phase == PH_DATA1 ||
         cur_i.phase == PH_DATA2)) begin
      res_o.status = s;
      res_o.single = one;
    end
    // meta result fields
    if (fire_o && (cur_i.phase == PH_MLEN || cur_i.phase == PH_MBODY)) begin
      res_o.status = StatMeta;
      res_o.mtype  = cur_i.mkind;
      if ({1'b0, cur_i.mkind} == MetaTempo) begin
        res_o.kind  = EV_TEMPO;
        res_o.tempo = nxt_o.tempo;
      end else if ({1'b0, cur_i.mkind} == MetaEot) begin
        res_o.kind = EV_EOT;
        nxt_o.done = 1'b1;
      end else begin
        res_o.kind = EV_META;
      end
    end
    if (fire_o) begin
      nxt_o.phase  = PH_DELTA;
      nxt_o.delta  = '0;
      nxt_o.dcount = '0;
    end
  end
endmodule

FILE: rtl/core/midi_track_event_parser_unit.sv
// Top level of the MIDI track event parser: handshake, track contexts, control.
// Path: an accepted byte is registered with its track, stepped against that track's
//   context, and its result loaded into the output register once the output is free;
//   a tempo event goes through the shared bit-serial divider, the x12 step, then that register.
// Flow: no new byte is taken until the last one is stepped (load context, step) or dropped,
//   nor until a byte that ends a tempo event has its result in the output register.
// Reset: rst_ni clears all track contexts and the output valid, and sets ticks per beat to 48.
module midi_track_event_parser_unit #(
  parameter int MaxTracks = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,      // ticks_per_beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,     // [3:0] track_index, [11:4] byte_value,
                                        // [12] track_restart, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [119:0] m_axis_tdata     // track_out, event_kind, delta_ticks,
                                        // status_value, first_data, second_data,
                                        // single_data, meta_type, tempo_us,
                                        // tick_period; low bits first, zero fill
);
  import mtep_pkg::*;

  localparam int IdxW = (MaxTracks > 1) ? $clog2(MaxTracks) : 1;

  track_t      ctx_q [MaxTracks];
  logic [15:0] tpb_q;
  ctrl_e       state_q, state_d;
  logic [3:0]  trk_q;
  logic [7:0]  byte_q;
  logic        rst_q;
  logic        hit_q;
  result_t     res_q, out_q;
  logic        ovld_q, ovld_d;

  track_t  cur, nxt;
  logic    fire;
  result_t res;
  logic    div_start, div_done;
  logic [23:0] quot;
  logic [IdxW-1:0] idx;
  logic    in_range;
  logic    accept, step_en;
  logic [27:0] q_x12;
  logic    load_step, load_tempo;

  assign idx      = trk_q[IdxW-1:0];
  assign in_range = ({28'd0, trk_q} < 32'(MaxTracks));
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !hit_q;

  // Apply restart before stepping.
  always_comb begin
    cur = ctx_q[idx];
    if (rst_q) cur = '0;
  end

  mtep_step u_step (
    .cur_i(cur), .byte_i(byte_q), .track_i(trk_q),
    .nxt_o(nxt), .fire_o(fire), .res_o(res)
  );

  assign step_en = hit_q && in_range && !cur.done && (!ovld_q || m_axis_tready);
  assign div_start = step_en && fire && res.kind == EV_TEMPO;

  mtep_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(res.tempo),
    .divisor_i(tpb_q), .done_o(div_done), .quot_o(quot)
  );

  // x12 as shift-and-add of the registered quotient
  assign q_x12 = {res_q.period[24:0], 3'b0} + {res_q.period[25:0], 2'b0};

  // Load the output register from the step or from the finished tempo path.
  assign load_step  = step_en && fire && (res.kind != EV_TEMPO);
  assign load_tempo = (state_q == ST_OUT) && (!ovld_q || m_axis_tready);

  always_comb begin
    ovld_d = ovld_q;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    if (load_step || load_tempo) ovld_d = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (div_start) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (!ovld_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hit_q   <= 1'b0;
      ovld_q  <= 1'b0;
      tpb_q   <= 16'd48;
      for (int i = 0; i < MaxTracks; i++) ctx_q[i] <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) tpb_q <= cfg_wdata_i;
      if (accept) hit_q <= 1'b1;
      else if (hit_q && (!in_range || cur.done || !ovld_q || m_axis_tready)) begin
        hit_q <= 1'b0;
        if (in_range) ctx_q[idx] <= step_en ? nxt : cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      trk_q  <= s_axis_tdata[3:0];
      byte_q <= s_axis_tdata[11:4];
      rst_q  <= s_axis_tdata[12];
    end
    if (div_start) res_q <= res;
    if (div_done) res_q.period <= {4'd0, quot};
    if (state_q == ST_MUL) res_q.period <= q_x12;
    if (load_step) out_q <= res;
    if (load_tempo) out_q <= res_q;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {3'b0, out_q.period, out_q.tempo, out_q.mtype, out_q.single,
                         out_q.d2, out_q.d1, out_q.status, out_q.delta, out_q.kind,
                         out_q.track};
endmodule

FILE: bench/midi_track_event_parser_unit_test.sv
// Testbench for the MIDI track event parser: directed and random stimulus, scoreboard prediction.
module midi_track_event_parser_unit_test;
  import mtep_pkg::*;

  // Per-track parse context kept by the predictor.
  typedef struct {
    phase_e      phase;
    logic [27:0] delta;
    logic [1:0]  dcount;
    logic [7:0]  rstat;
    logic [7:0]  cstat;
    logic [7:0]  held;
    logic [7:0]  mkind;
    logic [7:0]  left;
    logic [23:0] tempo;
    logic        done;
  } trk_ctx_t;

  // One decoded event as it should appear on the output.
  typedef struct {
    logic [3:0]  track;
    event_e      kind;
    logic [27:0] delta;
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic        single;
    logic [6:0]  mtype;
    logic [23:0] tempo;
    logic [27:0] period;
  } midi_event_t;

  class event_scoreboard;
    trk_ctx_t    ctx[16];
    logic [15:0] tpb;
    midi_event_t pending[$];
    int          errors;
    int          matched;

    function void clear_ctx(int t);
      ctx[t].phase = PH_DELTA; ctx[t].delta = '0; ctx[t].dcount = '0;
      ctx[t].rstat = '0; ctx[t].cstat = '0; ctx[t].held = '0;
      ctx[t].mkind = '0; ctx[t].left = '0; ctx[t].tempo = '0; ctx[t].done = 1'b0;
    endfunction

    function void reset_all();
      for (int t = 0; t < 16; t++) clear_ctx(t);
      tpb = 16'd48;
    endfunction

    // Close the event: push it and send the track back to the delta phase.
    function void close_event(int t, event_e k, logic [7:0] st, logic [6:0] a,
                              logic [6:0] b, logic one, logic [6:0] mt,
                              logic [23:0] tmp, logic [27:0] per);
      midi_event_t e;
      e.track = t[3:0]; e.kind = k; e.delta = ctx[t].delta; e.status = st;
      e.d1 = a; e.d2 = b; e.single = one; e.mtype = mt; e.tempo = tmp; e.period = per;
      pending.push_back(e);
      ctx[t].phase = PH_DELTA; ctx[t].delta = '0; ctx[t].dcount = '0;
    endfunction

    function void chan_event(int t, logic [7:0] a, logic [7:0] b);
      logic [7:0] s;
      logic       one;
      s = ctx[t].cstat;
      one = (s >= 8'hC0 && s <= 8'hDF);
      if (one) b = '0;
      else if (s[7:4] == 4'h9 && b == 8'd0) begin
        s = s & 8'h8F; b = 8'h7F;
      end
      close_event(t, EV_CHANNEL, s, a[6:0], b[6:0], one, '0, '0, '0);
    endfunction

    function void meta_done(int t);
      logic [6:0]  mt;
      logic [31:0] dv;
      logic [31:0] q;
      mt = ctx[t].mkind[6:0];
      if (mt == MetaTempo[6:0]) begin
        dv = (tpb == 0) ? 32'd1 : {16'd0, tpb};
        q = ({8'd0, ctx[t].tempo} / dv) * 12;
        close_event(t, EV_TEMPO, StatMeta, '0, '0, 1'b0, mt, ctx[t].tempo, q[27:0]);
      end else if (mt == MetaEot[6:0]) begin
        close_event(t, EV_EOT, StatMeta, '0, '0, 1'b0, mt, '0, '0);
        ctx[t].done = 1'b1;
      end else begin
        close_event(t, EV_META, StatMeta, '0, '0, 1'b0, mt, '0, '0);
      end
    endfunction

    // Note an accepted input byte and predict what it causes.
    function void note_byte(int t, logic [7:0] b, logic rs);
      if (rs) clear_ctx(t);
      if (ctx[t].done) return;
      case (ctx[t].phase)
        PH_DELTA: begin
          ctx[t].delta = {ctx[t].delta[20:0], b[6:0]};
          if (b[7] && ctx[t].dcount < 3) ctx[t].dcount++;
          else ctx[t].phase = PH_STATUS;
        end
        PH_STATUS: begin
          if (b < 8'h80) begin
            if (ctx[t].rstat < 8'h80 || ctx[t].rstat > 8'hEF)
              close_event(t, EV_ERROR, b, '0, '0, 1'b0, '0, '0, '0);
            else begin
              ctx[t].cstat = ctx[t].rstat;
              if (ctx[t].rstat >= 8'hC0 && ctx[t].rstat <= 8'hDF) chan_event(t, b, 8'd0);
              else begin
                ctx[t].held = b; ctx[t].phase = PH_DATA2;
              end
            end
          end else if (b == 8'hFF) ctx[t].phase = PH_MTYPE;
          else if (b <= 8'hEF) begin
            ctx[t].rstat = b; ctx[t].cstat = b; ctx[t].phase = PH_DATA1;
          end else close_event(t, EV_ERROR, b, '0, '0, 1'b0, '0, '0, '0);
        end
        PH_DATA1: begin
          if (b >= 8'h80) close_event(t, EV_ERROR, b, '0, '0, 1'b0, '0, '0, '0);
          else if (ctx[t].cstat >= 8'hC0 && ctx[t].cstat <= 8'hDF) chan_event(t, b, 8'd0);
          else begin
            ctx[t].held = b; ctx[t].phase = PH_DATA2;
          end
        end
        PH_DATA2: begin
          if (b >= 8'h80) close_event(t, EV_ERROR, b, '0, '0, 1'b0, '0, '0, '0);
          else chan_event(t, ctx[t].held, b);
        end
        PH_MTYPE: begin
          if (b >= 8'h80) close_event(t, EV_ERROR, b, '0, '0, 1'b0, '0, '0, '0);
          else begin
            ctx[t].mkind = b; ctx[t].phase = PH_MLEN;
          end
        end
        PH_MLEN: begin
          ctx[t].left = b; ctx[t].tempo = '0;
          if (b == 0) meta_done(t);
          else ctx[t].phase = PH_MBODY;
        end
        PH_MBODY: begin
          if (ctx[t].mkind == MetaTempo) ctx[t].tempo = {ctx[t].tempo[15:0], b};
          ctx[t].left = ctx[t].left - 8'd1;
          if (ctx[t].left == 0) meta_done(t);
        end
        default: ctx[t].phase = PH_DELTA;
      endcase
    endfunction

    // Compare one output transaction with the oldest predicted event.
    function void check_event(logic [119:0] d);
      midi_event_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected event, actual %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      cmp("track", 32'(e.track), 32'(d[3:0]));
      cmp("kind", 32'(e.kind), 32'(d[6:4]));
      cmp("delta", 32'(e.delta), 32'(d[34:7]));
      cmp("status", 32'(e.status), 32'(d[42:35]));
      cmp("data1", 32'(e.d1), 32'(d[49:43]));
      cmp("data2", 32'(e.d2), 32'(d[56:50]));
      cmp("single", 32'(e.single), 32'(d[57]));
      cmp("meta_type", 32'(e.mtype), 32'(d[64:58]));
      cmp("tempo", 32'(e.tempo), 32'(d[88:65]));
      cmp("period", 32'(e.period), 32'(d[116:89]));
    endfunction

    function void cmp(string f, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $realtime, f, exp_v, act_v);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;   // [3:0] track, [11:4] byte, [12] restart
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;        // event fields, track in the low bits

  event_scoreboard sb;
  int sent;
  bit stim_done;

  midi_track_event_parser_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Send one byte as a transaction after a random idle gap; hold valid when no gap.
  task automatic send_byte(logic [3:0] t, logic [7:0] b, logic rs = 1'b0);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, rs, b, t};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(int'(t), b, rs);
    sent++;
  endtask

  // Drop valid, wait for every predicted event, then let a tempo divide drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_tpb(logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tpb = v;
  endtask

  // Random delta of 1..4 bytes, occasionally long with all continuation bits.
  task automatic send_delta(logic [3:0] t);
    int n;
    n = $urandom_range(1, 4);
    for (int i = 1; i < n; i++) send_byte(t, 8'h80 | 8'($urandom_range(0, 127)));
    send_byte(t, 8'(($urandom_range(0, 5) == 0) ? $urandom_range(128, 255)
                                                 : $urandom_range(0, 127)));
  endtask

  // One event with random content on track t, or a noise byte.
  task automatic send_event(logic [3:0] t);
    int sel;
    int len;
    send_delta(t);
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      if ($urandom_range(0, 2) != 0) send_byte(t, 8'($urandom_range(8'h80, 8'hEF)));
      send_byte(t, 8'($urandom_range(0, 127)));
      send_byte(t, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 127)));
    end else if (sel < 8) begin
      send_byte(t, 8'hFF);
      send_byte(t, (sel == 5) ? MetaTempo : 8'($urandom_range(0, 127)));
      len = (sel == 5) ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 3)
                       : $urandom_range(0, 5);
      send_byte(t, 8'(len));
      for (int i = 0; i < len; i++) send_byte(t, 8'($urandom_range(0, 255)));
    end else if (sel == 8) begin
      send_byte(t, 8'hFF); send_byte(t, MetaEot); send_byte(t, 8'd0);
    end else begin
      send_byte(t, 8'($urandom_range(0, 255)));  // noise
    end
  endtask

  // Output side: random stalls per result, with runs of no stall.
  initial begin
    int st;
    wait (rst_ni);
    forever begin
      st = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (st > 0) begin
        m_axis_tready <= 1'b0;
        repeat (st) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_event(m_axis_tdata);
    end
  end

  initial begin
    sb = new();
    sb.reset_all();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: note-on zero velocity, program change, running status, long delta.
    send_byte(0, 8'h00); send_byte(0, 8'h93); send_byte(0, 8'h40); send_byte(0, 8'h00);
    send_byte(0, 8'h7F); send_byte(0, 8'h7F); send_byte(0, 8'h7F);
    send_byte(1, 8'hFF); send_byte(1, 8'hFF); send_byte(1, 8'hFF); send_byte(1, 8'hFF);
    send_byte(1, 8'hC5); send_byte(1, 8'h7F);
    send_byte(2, 8'h00); send_byte(2, 8'h22);                // no running status
    send_byte(2, 8'h00); send_byte(2, 8'hF0);                // system byte
    send_byte(3, 8'h00); send_byte(3, 8'hFF); send_byte(3, MetaTempo);
    send_byte(3, 8'h03); send_byte(3, 8'hFF); send_byte(3, 8'hFF); send_byte(3, 8'hFF);
    send_byte(4, 8'h00); send_byte(4, 8'hFF); send_byte(4, MetaEot); send_byte(4, 8'h00);
    send_byte(4, 8'h12);                                     // ignored, finished
    send_byte(4, 8'h05, 1'b1);                               // restart

    // Pause until all events are out, then sweep divisor settings.
    write_tpb(16'd0);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_tpb(16'd1);
        1: write_tpb(16'hFFFF);
        2: write_tpb(16'd48);
        default: write_tpb(16'($urandom_range(1, 65535)));
      endcase
      while (sent < 30 + (ph + 1) * 340) begin
        logic [3:0] t;
        t = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 40) == 0) send_byte(t, 8'($urandom_range(0, 255)), 1'b1);
        else send_event(t);
      end
    end
    drain();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("Sent %0d bytes on 16 tracks, %0d events checked, five divisor settings.",
             sent, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/mtep_pkg.sv
rtl/core/mtep_divider.sv
rtl/core/mtep_step.sv
rtl/core/midi_track_event_parser_unit.sv
bench/midi_track_event_parser_unit_test.sv
